### hw/rtl/dpq_pkg.sv
`default_nettype none

package dpq_pkg;

  // Fixed field widths of the request and result ports.
  localparam int KIND_BITS      = 2;
  localparam int VALUE_BITS     = 31;
  localparam int ITEM_PRIO_BITS = 16;
  localparam int STATUS_BITS    = 3;
  localparam int OCC_BITS       = 5;

  // Operation codes.
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/dpq_store.sv
`default_nettype none

module dpq_store #(
  parameter int CAPACITY = 16,
  parameter int ENTRY_BITS = 47
) (
  input  wire logic                        clk,
  input  wire logic                        mem_rd_en,
  input  wire logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
  output logic      [ENTRY_BITS-1:0]       mem_rd_data,
  input  wire logic                        mem_wr_en,
  input  wire logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
  input  wire logic [ENTRY_BITS-1:0]       mem_wr_data
);

  // Entry storage, one value and priority pair per slot, kept in queue order.
  logic [ENTRY_BITS-1:0] mem [CAPACITY];

  // One read port with registered data, one write port.
  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      mem_rd_data <= mem[mem_rd_addr];
    end
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dpq_ctrl.sv
`default_nettype none

module dpq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        start,
  input  wire logic [dpq_pkg::KIND_BITS-1:0]               kind,
  input  wire logic [dpq_pkg::VALUE_BITS-1:0]              item_value,
  input  wire logic [dpq_pkg::ITEM_PRIO_BITS-1:0]          item_priority,
  output logic                                             busy,
  output logic                                             done,
  output logic      [dpq_pkg::VALUE_BITS-1:0]              popped_value,
  output logic      [dpq_pkg::STATUS_BITS-1:0]             status,
  output logic      [dpq_pkg::OCC_BITS-1:0]                occupancy,
  output logic                                             mem_rd_en,
  output logic      [$clog2(CAPACITY)-1:0]                 mem_rd_addr,
  input  wire logic [dpq_pkg::VALUE_BITS+PRIORITY_BITS-1:0] mem_rd_data,
  output logic                                             mem_wr_en,
  output logic      [$clog2(CAPACITY)-1:0]                 mem_wr_addr,
  output logic      [dpq_pkg::VALUE_BITS+PRIORITY_BITS-1:0] mem_wr_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = PRIORITY_BITS;
  localparam int EW = dpq_pkg::VALUE_BITS + PW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                         state;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic [CW-1:0]                      rd_ptr;
  logic                               dv;
  logic [AW-1:0]                      dj;
  logic [dpq_pkg::KIND_BITS-1:0]      op;
  logic [dpq_pkg::VALUE_BITS-1:0]     val;
  logic [PW-1:0]                      pri;
  logic                               hit;
  logic [AW-1:0]                      hit_idx;
  logic                               pos_found;
  logic [AW-1:0]                      pos;
  logic [EW-1:0]                      carry;
  logic                               issue;
  logic                               is_ins;
  logic                               full;
  logic [dpq_pkg::VALUE_BITS-1:0]     rd_val;
  logic [PW-1:0]                      rd_pri;

  assign busy   = (state != S_IDLE);
  assign is_ins = (op == dpq_pkg::KIND_INSERT);
  assign full   = (count == CW'(CAPACITY));
  assign rd_val = mem_rd_data[EW-1 -: dpq_pkg::VALUE_BITS];
  assign rd_pri = mem_rd_data[PW-1:0];

  // Entry count after an insert or a delete that goes ahead.
  assign count_next = is_ins ? count + 1'b1 : count - 1'b1;

  // Reads stream through the occupied slots, one address per cycle.
  assign issue       = ((state == S_SCAN) || (state == S_MOVE)) && (rd_ptr < count);
  assign mem_rd_en   = issue;
  assign mem_rd_addr = rd_ptr[AW-1:0];

  // Write port. An insert ripples the held entry one slot up behind the read
  // stream; a delete copies each entry one slot down. The tail write of an
  // insert lands in the finishing cycle.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = dj;
    mem_wr_data = carry;
    if ((state == S_MOVE) && dv) begin
      if (is_ins) begin
        mem_wr_en = 1'b1;
      end else if (dj != hit_idx) begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = dj - AW'(1);
        mem_wr_data = mem_rd_data;
      end
    end else if ((state == S_FINISH) && is_ins) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = count[AW-1:0];
    end
  end

  // Sequencer, entry count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      dv    <= 1'b0;
    end else begin
      done <= 1'b0;
      dv   <= issue;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (kind)
              dpq_pkg::KIND_INSERT, dpq_pkg::KIND_REMOVE: begin
                state <= S_SCAN;
              end
              dpq_pkg::KIND_POP: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_MOVE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!issue && !dv) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (is_ins ? (hit || full) : !hit) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (!issue && !dv) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields, scan results, the held entry and the result registers.
  always_ff @(posedge clk) begin
    dj <= rd_ptr[AW-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          op           <= kind;
          val          <= item_value;
          pri          <= PW'(item_priority);
          rd_ptr       <= '0;
          hit          <= 1'b0;
          hit_idx      <= '0;
          pos_found    <= 1'b0;
          pos          <= '0;
          popped_value <= '0;
          status       <= (kind == dpq_pkg::KIND_POP) ? dpq_pkg::ST_EMPTY : dpq_pkg::ST_OK;
          occupancy    <= dpq_pkg::OCC_BITS'(count);
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        // First matching value, and first slot of strictly lower priority.
        if (dv) begin
          if ((rd_val == val) && !hit) begin
            hit     <= 1'b1;
            hit_idx <= dj;
          end
          if ((rd_pri < pri) && !pos_found) begin
            pos_found <= 1'b1;
            pos       <= dj;
          end
        end
      end
      S_DECIDE: begin
        carry <= {val, pri};
        if (is_ins) begin
          rd_ptr <= pos_found ? CW'(pos) : count;
          status <= hit ? dpq_pkg::ST_DUP : (full ? dpq_pkg::ST_FULL : dpq_pkg::ST_OK);
        end else begin
          rd_ptr <= CW'(hit_idx);
          status <= hit ? dpq_pkg::ST_OK : dpq_pkg::ST_NOTFOUND;
        end
      end
      S_MOVE: begin
        if (issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        // An insert holds the displaced entry; a delete keeps the removed one.
        if (dv && (is_ins || (dj == hit_idx))) begin
          carry <= mem_rd_data;
        end
      end
      S_FINISH: begin
        status       <= dpq_pkg::ST_OK;
        occupancy    <= dpq_pkg::OCC_BITS'(count_next);
        popped_value <= (op == dpq_pkg::KIND_POP) ? carry[EW-1 -: dpq_pkg::VALUE_BITS] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dedup_priority_queue.sv
`default_nettype none

// Priority queue of up to CAPACITY (value, priority) entries, highest priority
// first and first-come first-served among equal priorities, with no duplicate
// values. A request is taken at a clock edge where start is high and busy is
// low; kind selects insert, pop of the head, or removal by value.
// Each request gives exactly one result: done is high for one cycle with
// popped_value, status and occupancy. The receiver cannot hold results off,
// and the block never waits on it.
// Sequence of a request: a pop of an empty queue and an unused kind are
// answered from the idle state and leave busy low. A pop moves the entries
// behind the head and then updates the count. Insert and remove first read
// every entry and then decide; a rejected insert or a remove that misses
// answers from the decision. Otherwise the entries behind the affected slot
// are moved and the count is updated. The single read port of the entry
// memory paces these passes: one slot is read per cycle. busy is high from
// the accepting edge until the result.
// Reset empties the queue; stored entries are not cleared.

module dedup_priority_queue #(
  parameter int CAPACITY = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [dpq_pkg::KIND_BITS-1:0]      kind,
  input  wire logic [dpq_pkg::VALUE_BITS-1:0]     item_value,
  input  wire logic [dpq_pkg::ITEM_PRIO_BITS-1:0] item_priority,
  output logic                                    busy,
  output logic                                    done,
  output logic      [dpq_pkg::VALUE_BITS-1:0]     popped_value,
  output logic      [dpq_pkg::STATUS_BITS-1:0]    status,
  output logic      [dpq_pkg::OCC_BITS-1:0]       occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = dpq_pkg::VALUE_BITS + PRIORITY_BITS;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;

  // Sequencer and result registers.
  dpq_ctrl #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .item_value    (item_value),
    .item_priority (item_priority),
    .busy          (busy),
    .done          (done),
    .popped_value  (popped_value),
    .status        (status),
    .occupancy     (occupancy),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

  // Entry memory.
  dpq_store #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (EW)
  ) u_store (
    .clk         (clk),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

`ifndef ASSERT_OFF
  // The shifting passes never read a slot in the cycle it is written.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("entry memory read and written at the same slot");

  // A result after a busy cycle comes with busy low.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    (done && $past(busy)) |-> !busy)
    else $error("busy still high while a result is given");

  // A full rejection only happens with the queue full.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && (status == dpq_pkg::ST_FULL)) |-> (occupancy == dpq_pkg::OCC_BITS'(CAPACITY)))
    else $error("full status with free slots");

  // Only a successful pop returns a value.
  a_popped_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != dpq_pkg::ST_OK)) |-> (popped_value == '0))
    else $error("value returned with a failure status");
`endif

endmodule

`default_nettype wire
